### hdl/fps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_pkg
// shared types, constants and helpers of the frame pacing scheduler
// ----------------------------------------------------------------------------
package fps_pkg;

	localparam int TIME_BITS   = 48;
	localparam int NOW_W       = 48;
	localparam int CNT_W       = 32;
	localparam int SUM_W       = 64;
	localparam int PERIOD_W    = 30;
	localparam int LATE_W      = 10;
	localparam int LIMIT_W     = 30;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 30;
	localparam int DIV_STEPS   = SUM_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0]    NS_PER_MS      = 32'd1000000;
	localparam logic [CNT_W-1:0]    DEV_INIT       = 32'd1000000000;
	localparam logic [CNT_W-1:0]    CNT_MAX        = '1;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 30'd16666666;
	localparam logic [LATE_W-1:0]   LATENESS_RESET = 10'd2;

	typedef enum logic [1:0] {
		REQ_CHECK   = 2'd0,
		REQ_PRESENT = 2'd1,
		REQ_CLEAR   = 2'd2,
		REQ_START   = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PACING   = 2'd0,
		CFG_PERIOD   = 2'd1,
		CFG_LATENESS = 2'd2,
		CFG_UNUSED   = 2'd3
	} cfg_idx_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic calc_diff;
		logic calc_abs;
		logic update;
		logic div_init;
		logic div_step;
		logic load_out;
	} fps_cmd_t;

	function automatic logic [CNT_W-1:0] sat32(input logic [TIME_BITS-1:0] v);
		logic [CNT_W-1:0] r;
		r = (|v[TIME_BITS-1:CNT_W]) ? CNT_MAX : v[CNT_W-1:0];
		return r;
	endfunction

endpackage

### hdl/fps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_ctrl
// sequencer: takes one event, steps the datapath through it, owns out_valid
// ----------------------------------------------------------------------------
module fps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output fps_pkg::fps_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_ABS,
		S_UPD,
		S_DINIT,
		S_DIV,
		S_OUT
	} state_t;

	state_t                         state_q;
	logic [fps_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           out_valid_q;
	logic                           out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// result slot is free when empty or being drained this cycle
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.load_in   = in_valid && (state_q == S_IDLE);
		cmd.calc_diff = (state_q == S_DIFF);
		cmd.calc_abs  = (state_q == S_ABS);
		cmd.update    = (state_q == S_UPD);
		cmd.div_init  = (state_q == S_DINIT);
		cmd.div_step  = (state_q == S_DIV);
		cmd.load_out  = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result beat wins over draining the old one
			if ((state_q == S_OUT) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DIFF;
				end
				S_DIFF:  state_q <= S_ABS;
				S_ABS:   state_q <= S_UPD;
				S_UPD:   state_q <= S_DINIT;
				S_DINIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == fps_pkg::DIV_CNT_W'(fps_pkg::DIV_STEPS - 1))
						state_q <= S_OUT;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/fps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_dp
// datapath: config registers, deadline and statistics, deviation math,
// restoring divider for the average and the result register
// ----------------------------------------------------------------------------
module fps_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fps_pkg::fps_cmd_t                 cmd,
	input  logic                              cfg_we,
	input  logic [fps_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [fps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic [1:0]                        req_type,
	input  logic [fps_pkg::NOW_W-1:0]         now_ns,
	output logic                              render_ok,
	output logic [fps_pkg::CNT_W-1:0]         wait_ns,
	output logic [fps_pkg::CNT_W-1:0]         render_total,
	output logic [fps_pkg::CNT_W-1:0]         skip_total,
	output logic [fps_pkg::CNT_W-1:0]         avg_deviation_ns,
	output logic [fps_pkg::CNT_W-1:0]         min_deviation_ns,
	output logic [fps_pkg::CNT_W-1:0]         max_deviation_ns
);

	localparam int TB = fps_pkg::TIME_BITS;
	localparam int CW = fps_pkg::CNT_W;
	localparam int SW = fps_pkg::SUM_W;

	// configuration
	logic                           pacing_q;
	logic [fps_pkg::PERIOD_W-1:0]   period_q;
	logic [fps_pkg::LATE_W-1:0]     lateness_q;
	logic [fps_pkg::LIMIT_W-1:0]    limit_q;

	// scheduler state
	logic [TB-1:0]                  deadline_q;
	logic                           first_q;
	logic [CW-1:0]                  rcount_q;
	logic [CW-1:0]                  scount_q;
	logic [SW-1:0]                  sum_q;
	logic [CW-1:0]                  min_q;
	logic [CW-1:0]                  max_q;

	// per-event pipeline
	fps_pkg::req_t                  req_s1;
	logic [TB-1:0]                  now_s1;
	logic [TB:0]                    diff_s2;
	logic [CW-1:0]                  dev_s3;
	logic [CW-1:0]                  wait_s3;
	logic                           skip_s3;
	logic                           render_s4;
	logic [CW-1:0]                  wait_s4;

	// divider
	logic [CW-1:0]                  rem_q;
	logic [SW-1:0]                  quot_q;

	logic [TB-1:0]                  mag;
	logic                           late;
	logic [SW:0]                    sum_ext;
	logic [CW:0]                    shifted;
	logic                           ge;
	logic [CW:0]                    trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pacing_q   <= 1'b1;
			period_q   <= fps_pkg::PERIOD_RESET;
			lateness_q <= fps_pkg::LATENESS_RESET;
		end else if (cfg_we) begin
			unique case (fps_pkg::cfg_idx_t'(cfg_idx))
				fps_pkg::CFG_PACING:   pacing_q   <= cfg_wdata[0];
				fps_pkg::CFG_PERIOD:   period_q   <= cfg_wdata[fps_pkg::PERIOD_W-1:0];
				fps_pkg::CFG_LATENESS: lateness_q <= cfg_wdata[fps_pkg::LATE_W-1:0];
				default: ;
			endcase
		end
	end

	// lateness limit in ns, registered from the lateness setting
	always_ff @(posedge clk) begin
		limit_q <= fps_pkg::LIMIT_W'(CW'(lateness_q) * fps_pkg::NS_PER_MS);
	end

	// magnitude of now - deadline, borrow set when now is before the deadline
	assign mag  = diff_s2[TB] ? (TB'(0) - diff_s2[TB-1:0]) : diff_s2[TB-1:0];
	assign late = !diff_s2[TB] && (|diff_s2[TB-1:0]);

	assign sum_ext = {1'b0, sum_q} + SW'(dev_s3);

	assign shifted = {rem_q, quot_q[SW-1]};
	assign ge      = shifted >= {1'b0, rcount_q};
	assign trial   = shifted - {1'b0, rcount_q};

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_s1 <= fps_pkg::req_t'(req_type);
			now_s1 <= now_ns[TB-1:0];
		end
		if (cmd.calc_diff)
			diff_s2 <= {1'b0, now_s1} - {1'b0, deadline_q};
		if (cmd.calc_abs) begin
			dev_s3  <= fps_pkg::sat32(mag);
			wait_s3 <= late ? '0 : fps_pkg::sat32(mag);
			skip_s3 <= late && (mag > TB'(limit_q));
		end
		if (cmd.update) begin
			render_s4 <= !((req_s1 == fps_pkg::REQ_CHECK) && pacing_q && skip_s3);
			wait_s4   <= ((req_s1 == fps_pkg::REQ_CHECK) && pacing_q) ? wait_s3 : '0;
		end
		if (cmd.div_init) begin
			rem_q  <= '0;
			quot_q <= sum_q;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? trial[CW-1:0] : shifted[CW-1:0];
			quot_q <= {quot_q[SW-2:0], ge};
		end
		if (cmd.load_out) begin
			render_ok        <= render_s4;
			wait_ns          <= wait_s4;
			render_total     <= rcount_q;
			skip_total       <= scount_q;
			min_deviation_ns <= min_q;
			max_deviation_ns <= max_q;
			if (rcount_q == '0)
				avg_deviation_ns <= '0;
			else if (|quot_q[SW-1:CW])
				avg_deviation_ns <= fps_pkg::CNT_MAX;
			else
				avg_deviation_ns <= quot_q[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_q <= '0;
			first_q    <= 1'b1;
			rcount_q   <= '0;
			scount_q   <= '0;
			sum_q      <= '0;
			min_q      <= fps_pkg::DEV_INIT;
			max_q      <= '0;
		end else if (cmd.update) begin
			unique case (req_s1)
				fps_pkg::REQ_START: begin
					deadline_q <= now_s1;
					first_q    <= 1'b1;
					rcount_q   <= '0;
					scount_q   <= '0;
					sum_q      <= '0;
					min_q      <= fps_pkg::DEV_INIT;
					max_q      <= '0;
				end
				fps_pkg::REQ_CLEAR: begin
					rcount_q <= '0;
					scount_q <= '0;
					sum_q    <= '0;
					min_q    <= fps_pkg::DEV_INIT;
					max_q    <= '0;
				end
				fps_pkg::REQ_CHECK: begin
					if (pacing_q && skip_s3 && scount_q != fps_pkg::CNT_MAX)
						scount_q <= scount_q + 1'b1;
				end
				fps_pkg::REQ_PRESENT: begin
					if (pacing_q) begin
						if (rcount_q != fps_pkg::CNT_MAX)
							rcount_q <= rcount_q + 1'b1;
						sum_q <= sum_ext[SW] ? '1 : sum_ext[SW-1:0];
						if (dev_s3 > max_q)
							max_q <= dev_s3;
						if (dev_s3 < min_q)
							min_q <= dev_s3;
						// first frame re-anchors, later ones advance by a period
						if (first_q) begin
							deadline_q <= now_s1;
							first_q    <= 1'b0;
						end else begin
							deadline_q <= now_s1 + TB'(period_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### hdl/frame_pacing_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_pacing_scheduler
// frame deadline tracking with skip decision and deviation statistics
// ----------------------------------------------------------------------------
// Takes one timestamped event per beat (check frame, frame presented, reset
// statistics, start) and returns one result beat with the render decision,
// the wait until the deadline and the current statistics. Each event goes
// through three steps of deviation and update math, one step to seed the
// divider, a bit-serial restoring divider that forms the average deviation,
// then the result register load. The next event can be accepted in the cycle
// after that load; no new event is taken while one is in flight. A new event
// is accepted as soon as the previous one has gone into the result register,
// even while that result still waits to be taken; a result that is not taken
// holds the following event at the result load. Config writes take effect
// before the next event uses them and are expected only while the block is
// idle.
module frame_pacing_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fps_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     req_type,
	input  logic [fps_pkg::NOW_W-1:0]      now_ns,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           render_ok,
	output logic [fps_pkg::CNT_W-1:0]      wait_ns,
	output logic [fps_pkg::CNT_W-1:0]      render_total,
	output logic [fps_pkg::CNT_W-1:0]      skip_total,
	output logic [fps_pkg::CNT_W-1:0]      avg_deviation_ns,
	output logic [fps_pkg::CNT_W-1:0]      min_deviation_ns,
	output logic [fps_pkg::CNT_W-1:0]      max_deviation_ns
);

	fps_pkg::fps_cmd_t cmd;

	fps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	fps_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata),
		.req_type         (req_type),
		.now_ns           (now_ns),
		.render_ok        (render_ok),
		.wait_ns          (wait_ns),
		.render_total     (render_total),
		.skip_total       (skip_total),
		.avg_deviation_ns (avg_deviation_ns),
		.min_deviation_ns (min_deviation_ns),
		.max_deviation_ns (max_deviation_ns)
	);

`ifndef SYNTHESIS
	// one event at a time: busy right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an event is in flight");

	// a skipped frame never reports a wait and always shows in the skip count
	a_skip_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !render_ok |-> wait_ns == '0 && skip_total != '0)
		else $error("skip result with nonzero wait or zero skip count");

	// with nothing rendered the average and max must be zero
	a_empty_stats: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && render_total == '0 |-> avg_deviation_ns == '0
			&& max_deviation_ns == '0)
		else $error("statistics not empty with zero rendered frames");
`endif

endmodule

### dv/fps_pacing_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_pacing_monitor
// watches the event and result channels and checks every result beat
// ----------------------------------------------------------------------------
// Keeps its own copy of the pacing state and the register settings, works out
// the result of each accepted event beat and compares every accepted result
// beat against the oldest outstanding prediction, field by field.
module fps_pacing_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fps_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fps_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [1:0]                     req_type,
	input  logic [fps_pkg::NOW_W-1:0]      now_ns,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           render_ok,
	input  logic [fps_pkg::CNT_W-1:0]      wait_ns,
	input  logic [fps_pkg::CNT_W-1:0]      render_total,
	input  logic [fps_pkg::CNT_W-1:0]      skip_total,
	input  logic [fps_pkg::CNT_W-1:0]      avg_deviation_ns,
	input  logic [fps_pkg::CNT_W-1:0]      min_deviation_ns,
	input  logic [fps_pkg::CNT_W-1:0]      max_deviation_ns,
	output int                             fail_count,
	output int                             backlog
);
	import fps_pkg::*;

	typedef struct packed {
		logic             render_ok;
		logic [CNT_W-1:0] wait_ns;
		logic [CNT_W-1:0] rendered;
		logic [CNT_W-1:0] skipped;
		logic [CNT_W-1:0] avg_dev;
		logic [CNT_W-1:0] min_dev;
		logic [CNT_W-1:0] max_dev;
	} pace_result_t;

	// register copies
	logic                pace_on;
	logic [PERIOD_W-1:0] period;
	logic [LATE_W-1:0]   late_ms;

	// pacing state
	logic [TIME_BITS-1:0] deadline;
	logic                 first_due;
	logic [CNT_W-1:0]     rendered_cnt;
	logic [CNT_W-1:0]     skipped_cnt;
	logic [SUM_W-1:0]     dev_sum;
	logic [CNT_W-1:0]     dev_min;
	logic [CNT_W-1:0]     dev_max;

	pace_result_t pace_results_q[$];
	pace_result_t predicted;
	pace_result_t observed;

	function automatic logic [CNT_W-1:0] clamp_u32(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? '1 : v[CNT_W-1:0];
	endfunction

	task automatic wipe_stats();
		rendered_cnt = '0;
		skipped_cnt  = '0;
		dev_sum      = '0;
		dev_min      = DEV_INIT;
		dev_max      = '0;
	endtask

	task automatic pace_event(input req_t kind, input logic [NOW_W-1:0] stamp,
			output pace_result_t res);
		logic [TIME_BITS-1:0] now_t;
		logic [TIME_BITS-1:0] gap;
		logic [CNT_W-1:0]     dev;
		logic [63:0]          late_limit;
		begin
			now_t         = stamp[TIME_BITS-1:0];
			res           = '0;
			res.render_ok = 1'b1;
			case (kind)
				REQ_START: begin
					deadline  = now_t;
					first_due = 1'b1;
					wipe_stats();
				end
				REQ_CLEAR: wipe_stats();
				default: begin
					if (pace_on && kind == REQ_CHECK) begin
						if (now_t > deadline) begin
							gap        = now_t - deadline;
							late_limit = 64'(late_ms) * 64'(NS_PER_MS);
							// strictly past the limit skips
							if (64'(gap) > late_limit) begin
								res.render_ok = 1'b0;
								if (skipped_cnt != '1)
									skipped_cnt = skipped_cnt + 1;
							end
						end else begin
							res.wait_ns = clamp_u32(64'(deadline - now_t));
						end
					end else if (pace_on) begin
						gap = (now_t >= deadline) ? now_t - deadline : deadline - now_t;
						dev = clamp_u32(64'(gap));
						if (rendered_cnt != '1)
							rendered_cnt = rendered_cnt + 1;
						if (dev_sum > ~64'd0 - 64'(dev))
							dev_sum = '1;
						else
							dev_sum = dev_sum + 64'(dev);
						if (dev > dev_max)
							dev_max = dev;
						if (dev < dev_min)
							dev_min = dev;
						if (first_due) begin
							deadline  = now_t;
							first_due = 1'b0;
						end else begin
							// wraps at the time width
							deadline = now_t + TIME_BITS'(period);
						end
					end
				end
			endcase
			res.rendered = rendered_cnt;
			res.skipped  = skipped_cnt;
			res.min_dev  = dev_min;
			res.max_dev  = dev_max;
			if (rendered_cnt != '0)
				res.avg_dev = clamp_u32(dev_sum / 64'(rendered_cnt));
		end
	endtask

	task automatic check_field(input string label, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] seen);
		if (want !== seen) begin
			fail_count = fail_count + 1;
			$display("t=%0d ns: %s mismatch, expected %0d, actual %0d",
				$time, label, want, seen);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pace_on   = 1'b1;
			period    = PERIOD_RESET;
			late_ms   = LATENESS_RESET;
			deadline  = '0;
			first_due = 1'b1;
			wipe_stats();
			pace_results_q.delete();
			fail_count = 0;
			backlog    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_PACING:   pace_on = cfg_wdata[0];
					CFG_PERIOD:   period  = cfg_wdata[PERIOD_W-1:0];
					CFG_LATENESS: late_ms = cfg_wdata[LATE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pace_results_q.size() == 0) begin
					fail_count = fail_count + 1;
					$display("t=%0d ns: stray result beat, expected none, %s%0b wait_ns=%0d",
						$time, "actual render_ok=", render_ok, wait_ns);
				end else begin
					observed = pace_results_q.pop_front();
					check_field("render_ok", 32'(observed.render_ok), 32'(render_ok));
					check_field("wait_ns", observed.wait_ns, wait_ns);
					check_field("render_total", observed.rendered, render_total);
					check_field("skip_total", observed.skipped, skip_total);
					check_field("avg_deviation_ns", observed.avg_dev, avg_deviation_ns);
					check_field("min_deviation_ns", observed.min_dev, min_deviation_ns);
					check_field("max_deviation_ns", observed.max_dev, max_deviation_ns);
				end
			end
			if (in_valid && in_ready) begin
				pace_event(req_t'(req_type), now_ns, predicted);
				pace_results_q.push_back(predicted);
			end
			backlog = pace_results_q.size();
		end
	end

endmodule

### dv/tb_frame_pacing_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_pacing_scheduler
// stimulus and verdict for the frame pacing scheduler
// ----------------------------------------------------------------------------
// Drives a directed set of boundary events, then timed frame sequences (start,
// checks around the deadline and lateness limit, presents with small and huge
// deviations) mixed with random events, across several register settings.
// Both channels idle at random; once the result side holds off long enough to
// back the block up. Checking is done in fps_pacing_monitor.
module tb_frame_pacing_scheduler;
	import fps_pkg::*;

	localparam int EVENT_COUNT  = 1700;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int STALL_CYCLES = 500;
	localparam int DRAIN_CYCLES = 100;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            req_type;
	logic [NOW_W-1:0]      now_ns;
	logic                  out_valid;
	logic                  out_ready;
	logic                  render_ok;
	logic [CNT_W-1:0]      wait_ns;
	logic [CNT_W-1:0]      render_total;
	logic [CNT_W-1:0]      skip_total;
	logic [CNT_W-1:0]      avg_deviation_ns;
	logic [CNT_W-1:0]      min_deviation_ns;
	logic [CNT_W-1:0]      max_deviation_ns;
	int                    fail_count;
	int                    backlog;

	// what the stimulus believes the block is set to
	logic                  cur_pace;
	logic [PERIOD_W-1:0]   cur_period;
	logic [LATE_W-1:0]     cur_late;

	bit src_steady;
	bit sink_steady;
	bit stall_req;
	bit stall_done;
	int beats_sent;
	int next_reconfig;
	int watchdog_cycles;

	frame_pacing_scheduler DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.now_ns           (now_ns),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.render_ok        (render_ok),
		.wait_ns          (wait_ns),
		.render_total     (render_total),
		.skip_total       (skip_total),
		.avg_deviation_ns (avg_deviation_ns),
		.min_deviation_ns (min_deviation_ns),
		.max_deviation_ns (max_deviation_ns)
	);

	fps_pacing_monitor pacing_mon (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.req_type         (req_type),
		.now_ns           (now_ns),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.render_ok        (render_ok),
		.wait_ns          (wait_ns),
		.render_total     (render_total),
		.skip_total       (skip_total),
		.avg_deviation_ns (avg_deviation_ns),
		.min_deviation_ns (min_deviation_ns),
		.max_deviation_ns (max_deviation_ns),
		.fail_count       (fail_count),
		.backlog          (backlog)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [NOW_W-1:0] rand_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[NOW_W-1:0];
	endfunction

	task automatic send_beat(input req_t kind, input logic [NOW_W-1:0] stamp);
		if (!src_steady) begin
			while ($urandom_range(0, 99) < 21) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= kind;
		now_ns   <= stamp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// only while nothing is in flight
	task automatic configure(input logic pace, input logic [PERIOD_W-1:0] period,
			input logic [LATE_W-1:0] late);
		@(negedge clk);
		in_valid <= 1'b0;
		wait (backlog == 0);
		write_reg(CFG_PACING, {29'($urandom), pace});
		write_reg(CFG_PERIOD, period);
		write_reg(CFG_LATENESS, {20'($urandom), late});
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_UNUSED, 30'($urandom));
		@(negedge clk);
		cfg_we     <= 1'b0;
		cur_pace   = pace;
		cur_period = period;
		cur_late   = late;
	endtask

	// start, then checks and presents placed around the running deadline
	task automatic frame_run(input int frames);
		logic [NOW_W-1:0] due;
		logic [NOW_W-1:0] stamp;
		logic [NOW_W-1:0] presented;
		logic [63:0]      late_ns;
		bit               first;
		begin
			if ($urandom_range(0, 3) == 0)
				due = '1 - 48'($urandom_range(0, 100000000));
			else
				due = rand_time();
			send_beat(REQ_START, due);
			first   = 1'b1;
			late_ns = 64'(cur_late) * 64'd1000000;
			for (int f = 0; f < frames; f++) begin
				if ($urandom_range(0, 9) != 0) begin
					case ($urandom_range(0, 7))
						0: stamp = due - 48'($urandom_range(1, 32'(cur_period) + 1));
						1: stamp = due;
						2: stamp = due + 48'(late_ns);
						3: stamp = due + 48'(late_ns) + 48'd1;
						4: stamp = due + 48'((64'($urandom_range(0, 1000)) * late_ns) / 1000);
						5: stamp = due + 48'(late_ns) + 48'($urandom_range(2, 32'hFFFF_FFFF));
						// far ahead of the deadline, wait saturates
						6: stamp = due - 48'({32'($urandom_range(1, 4)), $urandom});
						default: stamp = ($urandom_range(0, 1) != 0) ? due + 48'd1 : due - 48'd1;
					endcase
					send_beat(REQ_CHECK, stamp);
				end
				case ($urandom_range(0, 5))
					0: presented = due;
					1: presented = due - 48'($urandom_range(0, 200000));
					2: presented = due + 48'({32'($urandom_range(0, 7)), $urandom});
					default: presented = due + 48'($urandom_range(0, 200000));
				endcase
				send_beat(REQ_PRESENT, presented);
				if (cur_pace) begin
					due   = first ? presented : presented + 48'(cur_period);
					first = 1'b0;
				end
				if ($urandom_range(0, 19) == 0)
					send_beat(REQ_CLEAR, rand_time());
			end
		end
	endtask

	// result side
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_req) begin
				out_ready <= 1'b0;
				repeat (STALL_CYCLES) @(negedge clk);
				stall_req = 1'b0;
			end
			out_ready <= sink_steady || ($urandom_range(0, 99) >= 21);
		end
	end

	initial begin
		watchdog_cycles = 0;
		while (watchdog_cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			watchdog_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_idx     = CFG_PACING;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		req_type    = REQ_CHECK;
		now_ns      = '0;
		src_steady  = 1'b0;
		sink_steady = 1'b0;
		stall_req   = 1'b0;
		stall_done  = 1'b0;
		beats_sent  = 0;
		cur_pace    = 1'b1;
		cur_period  = PERIOD_RESET;
		cur_late    = LATENESS_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// boundary events under the reset settings
		send_beat(REQ_CHECK, 48'd0);
		send_beat(REQ_CHECK, 48'd2000000);
		send_beat(REQ_CHECK, 48'd2000001);
		send_beat(REQ_PRESENT, '1);
		send_beat(REQ_CHECK, '1 - 48'd5);
		send_beat(REQ_CHECK, 48'd0);
		// deadline wraps past zero
		send_beat(REQ_PRESENT, '1 - 48'd100);
		send_beat(REQ_CHECK, 48'd0);
		send_beat(REQ_CHECK, 48'd16666565);
		send_beat(REQ_CHECK, 48'd18666566);
		send_beat(REQ_PRESENT, 48'd16666565);
		send_beat(REQ_CLEAR, rand_time());
		send_beat(REQ_PRESENT, 48'd1);
		send_beat(REQ_START, '1);
		send_beat(REQ_CHECK, '1);
		send_beat(REQ_START, 48'd0);
		send_beat(REQ_PRESENT, 48'd1000);
		send_beat(REQ_PRESENT, 48'd1000 + 48'd16666666 - 48'd50);
		send_beat(REQ_CLEAR, 48'd0);

		configure(1'b1, 30'd1, 10'd0);
		frame_run(8);
		configure(1'b1, 30'h3FFF_FFFF, 10'd1023);
		frame_run(6);
		configure(1'b0, 30'($urandom_range(1, 1000000000)), 10'($urandom));
		for (int i = 0; i < 12; i++)
			send_beat(req_t'($urandom_range(0, 3)), rand_time());
		frame_run(4);
		// zero period is taken as is
		configure(1'b1, 30'd0, 10'd2);
		frame_run(4);

		next_reconfig = beats_sent;
		while (beats_sent < EVENT_COUNT) begin
			if (beats_sent >= next_reconfig) begin
				case ($urandom_range(0, 5))
					0: cur_period = 30'd1;
					1: cur_period = 30'h3FFF_FFFF;
					2: cur_period = PERIOD_RESET;
					3: cur_period = 30'($urandom_range(1, 1000000000));
					4: cur_period = 30'd0;
					default: cur_period = 30'($urandom_range(1, 5000));
				endcase
				case ($urandom_range(0, 4))
					0: cur_late = 10'd0;
					1: cur_late = 10'd1023;
					2: cur_late = 10'd2;
					default: cur_late = 10'($urandom_range(0, 1023));
				endcase
				configure($urandom_range(0, 4) != 0, cur_period, cur_late);
				next_reconfig = beats_sent + 150;
			end
			if (!stall_done && beats_sent > 500) begin
				stall_req  = 1'b1;
				stall_done = 1'b1;
				// keep offering beats while the result side holds off
				repeat (4)
					send_beat(req_t'($urandom_range(0, 3)), rand_time());
			end
			src_steady  = (beats_sent >= 900 && beats_sent < 1150);
			sink_steady = src_steady;
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6))
					send_beat(req_t'($urandom_range(0, 3)), rand_time());
			end else begin
				frame_run($urandom_range(2, 12));
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait (backlog == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
